@@ src/ihex_pkg.sv @@
// ----------------------------------------------------------------------------
// Intel HEX record parser package
// Shared types, parse phase codes, status codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam int CharWidth    = 8;
  localparam int AddrWidth    = 16;
  localparam int ByteWidth    = 8;
  localparam int StatusWidth  = 3;
  localparam int OutDataWidth = 32;

  localparam logic [3:0] PhStart = 4'd0;
  localparam logic [3:0] PhLen   = 4'd1;
  localparam logic [3:0] PhAddr  = 4'd2;
  localparam logic [3:0] PhType  = 4'd3;
  localparam logic [3:0] PhData  = 4'd4;
  localparam logic [3:0] PhCsum  = 4'd5;
  localparam logic [3:0] PhSkip  = 4'd6;

  localparam logic [StatusWidth-1:0] StOk      = 3'd0;
  localparam logic [StatusWidth-1:0] StCsum    = 3'd1;
  localparam logic [StatusWidth-1:0] StStart   = 3'd2;
  localparam logic [StatusWidth-1:0] StExtAddr = 3'd3;
  localparam logic [StatusWidth-1:0] StBadHex  = 3'd4;
  localparam logic [StatusWidth-1:0] StEof     = 3'd5;

  localparam logic [CharWidth-1:0] ChColon    = 8'h3a;
  localparam logic [CharWidth-1:0] ChLineFeed = 8'h0a;

  localparam logic [ByteWidth-1:0] KindData    = 8'h00;
  localparam logic [ByteWidth-1:0] KindEof     = 8'h01;
  localparam logic [ByteWidth-1:0] KindExtAddr = 8'h02;

  typedef struct packed {
    logic [3:0]           phase;
    logic                 digit_half;
    logic [3:0]           high_nibble;
    logic [ByteWidth-1:0] field_count;
    logic [ByteWidth-1:0] remaining_bytes;
    logic [AddrWidth-1:0] record_address;
    logic [ByteWidth-1:0] running_sum;
    logic                 stopped;
  } parse_state_t;

  typedef struct packed {
    logic                   halted;
    logic [StatusWidth-1:0] record_status;
    logic                   record_event;
    logic [ByteWidth-1:0]   byte_value;
    logic [AddrWidth-1:0]   byte_address;
    logic                   byte_valid;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] nibble;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [CharWidth-1:0] c);
    hex_digit_t d;
    d.valid  = 1'b1;
    d.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.nibble = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.nibble = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.nibble = 4'(c - 8'h37);
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

@@ src/ihex_step.sv @@
// ----------------------------------------------------------------------------
// Intel HEX parse step
// Next parse state and the result word for one character.
// ----------------------------------------------------------------------------
module ihex_step
  import ihex_pkg::*;
(
  input  parse_state_t         cur,
  input  logic [CharWidth-1:0] ch,
  output parse_state_t         nxt,
  output result_t              res
);

  hex_digit_t           digit;
  logic [ByteWidth-1:0] full_byte;
  logic [ByteWidth-1:0] sum_plus;
  logic [ByteWidth-1:0] rem_dec;

  always_comb begin
    digit     = hex_decode(ch);
    full_byte = {cur.high_nibble, digit.nibble};
    sum_plus  = cur.running_sum + full_byte;
    rem_dec   = cur.remaining_bytes - 8'd1;
    nxt       = cur;
    res       = '0;

    if (!cur.stopped) begin
      if (cur.phase == PhSkip) begin
        if (ch == ChLineFeed) begin
          nxt.phase = PhStart;
        end
      end else if (cur.phase < PhLen || cur.phase > PhCsum) begin
        if (ch == ChColon) begin
          nxt.phase       = PhLen;
          nxt.digit_half  = 1'b0;
          nxt.field_count = '0;
          nxt.running_sum = '0;
        end else begin
          res.record_event  = 1'b1;
          res.record_status = StStart;
          nxt.stopped       = 1'b1;
        end
      end else if (!digit.valid) begin
        res.record_event  = 1'b1;
        res.record_status = StBadHex;
        nxt.stopped       = 1'b1;
      end else if (!cur.digit_half) begin
        nxt.high_nibble = digit.nibble;
        nxt.digit_half  = 1'b1;
      end else begin
        nxt.digit_half = 1'b0;
        case (cur.phase)
          PhLen: begin
            nxt.remaining_bytes = full_byte;
            nxt.running_sum     = full_byte;
            nxt.field_count     = '0;
            nxt.phase           = PhAddr;
          end
          PhAddr: begin
            nxt.running_sum = sum_plus;
            if (cur.field_count == '0) begin
              nxt.record_address = {full_byte, 8'h00};
              nxt.field_count    = 8'd1;
            end else begin
              nxt.record_address = {cur.record_address[AddrWidth-1:8], full_byte};
              nxt.field_count    = '0;
              nxt.phase          = PhType;
            end
          end
          PhType: begin
            nxt.running_sum = sum_plus;
            nxt.field_count = '0;
            if (full_byte == KindData) begin
              nxt.phase = (cur.remaining_bytes == '0) ? PhCsum : PhData;
            end else if (full_byte == KindEof) begin
              res.record_event  = 1'b1;
              res.record_status = StEof;
              nxt.stopped       = 1'b1;
            end else if (full_byte == KindExtAddr) begin
              res.record_event  = 1'b1;
              res.record_status = StExtAddr;
              nxt.stopped       = 1'b1;
            end else begin
              nxt.phase = PhSkip;
            end
          end
          PhData: begin
            res.byte_valid      = 1'b1;
            res.byte_address    = cur.record_address + {8'h00, cur.field_count};
            res.byte_value      = full_byte;
            nxt.running_sum     = sum_plus;
            nxt.field_count     = cur.field_count + 8'd1;
            nxt.remaining_bytes = rem_dec;
            if (rem_dec == '0) begin
              nxt.phase = PhCsum;
            end
          end
          default: begin
            res.record_event = 1'b1;
            if (sum_plus == '0) begin
              res.record_status = StOk;
              nxt.phase         = PhSkip;
            end else begin
              res.record_status = StCsum;
              nxt.stopped       = 1'b1;
            end
          end
        endcase
      end
    end

    res.halted = nxt.stopped;
  end

endmodule

@@ src/ihex_skid.sv @@
// ----------------------------------------------------------------------------
// Output skid buffer
// Two-entry output register; input ready comes straight from a flop.
// ----------------------------------------------------------------------------
module ihex_skid
  import ihex_pkg::*;
#(
  parameter int Width = OutDataWidth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [Width-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [Width-1:0] out_data
);

  logic             main_valid;
  logic [Width-1:0] main_data;
  logic             skid_valid;
  logic [Width-1:0] skid_data;
  logic             push;
  logic             pop;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign push      = in_valid && in_ready;
  assign pop       = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_data  <= in_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

endmodule

@@ src/intel_hex_record_parser.sv @@
// ----------------------------------------------------------------------------
// Intel HEX record parser
//
//   Channel  Dir  Signals               Carries
//   s        in   s_tvalid/tready/tdata one character per word
//   m        out  m_tvalid/tready/tdata one result per character, tlast = record event
//
// One character is taken per cycle while s_tready is high; its result is registered.
// The parse state updates in the cycle a character is accepted.
// A two-entry output buffer absorbs one word of stall; s_tready is a flop.
// Reset returns the parser to start of line and empties the output buffer.
// ----------------------------------------------------------------------------
module intel_hex_record_parser
  import ihex_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [CharWidth-1:0]    s_tdata,   // [7:0] ch
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // [0] byte_valid, [16:1] byte_address, [24:17] byte_value,
  // [27:25] record_status, [28] halted, [31:29] zero
  output logic [OutDataWidth-1:0] m_tdata,
  output logic                    m_tlast    // record_event
);

  parse_state_t          state;
  parse_state_t          state_next;
  result_t               res;
  logic                  accept;
  logic [OutDataWidth:0] packed_word;
  logic [OutDataWidth:0] out_word;

  assign accept = s_tvalid && s_tready;

  ihex_step u_step (
    .cur (state),
    .ch  (s_tdata),
    .nxt (state_next),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_comb begin
    packed_word = '0;
    packed_word[0]     = res.byte_valid;
    packed_word[16:1]  = res.byte_address;
    packed_word[24:17] = res.byte_value;
    packed_word[27:25] = res.record_status;
    packed_word[28]    = res.halted;
    packed_word[OutDataWidth] = res.record_event;
  end

  ihex_skid #(
    .Width (OutDataWidth + 1)
  ) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (packed_word),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_word)
  );

  assign m_tdata = out_word[OutDataWidth-1:0];
  assign m_tlast = out_word[OutDataWidth];

endmodule

@@ src/ihex_checker.sv @@
// ----------------------------------------------------------------------------
// Intel HEX record parser checker
// Port-level checks on the result stream and on s_tready, bound to the top level.
// ----------------------------------------------------------------------------
module ihex_checker
  import ihex_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    s_tready,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [OutDataWidth-1:0] m_tdata,
  input logic                    m_tlast
);

  logic halt_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      halt_seen <= 1'b0;
    end else if (m_tvalid && m_tready && m_tdata[28]) begin
      halt_seen <= 1'b1;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && halt_seen |-> m_tdata[28] && !m_tlast && !m_tdata[0])
    else $error("word after a halt carries an event or a byte");

  a_byte_or_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tlast))
    else $error("byte and record event in the same word");

  a_status_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[27:25] == StOk)
    else $error("nonzero status without a record event");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && m_tdata[27:25] != StOk |-> m_tdata[28])
    else $error("error or end-of-file status without halt");

  a_ready_backed: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled while no result is pending");

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (.*);

@@ tb/sv/tb_intel_hex_record_parser.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Intel HEX record parser testbench
// Streams hex image text into the parser one character per word, with random
// gaps on the input and random back-pressure on the output. A local model of
// the parse state predicts every result word, and the monitor compares each
// word field by field. The run opens with a few hand-built records: an empty
// record, an address that wraps, lowercase digits, and skipped record types
// that carry stray bytes. Well-formed records with random content follow.
// One halting case, drawn at random, closes the run, and then characters that
// the halted parser must ignore.
// ----------------------------------------------------------------------------
module tb_intel_hex_record_parser;
  import ihex_pkg::*;

  localparam int ItemTarget = 450;
  localparam int StallLimit = 2000;
  localparam int LongHold   = 150;
  localparam int HoldAfter  = 120;
  localparam int TailCycles = 20;

  localparam logic [CharWidth-1:0] ChReturn = 8'h0d;

  typedef enum int {CaseUpper, CaseLower, CaseMixed} letter_case_t;
  typedef enum int {FillRandom, FillZero, FillOnes, FillCount} fill_t;
  typedef enum int {EndChecksum, EndBadStart, EndBadHex, EndEof, EndExtAddr} ending_t;

  typedef struct {
    logic [CharWidth-1:0] ch;
    bit                   drain_first;
  } hex_char_t;

  typedef struct packed {
    logic                   halted;
    logic [StatusWidth-1:0] status;
    logic                   rec_event;
    logic [ByteWidth-1:0]   value;
    logic [AddrWidth-1:0]   address;
    logic                   byte_valid;
  } parse_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [CharWidth-1:0]    s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OutDataWidth-1:0] m_tdata;
  logic                    m_tlast;

  intel_hex_record_parser uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Local copy of the parse state.
  logic [3:0]           line_phase;
  logic                 second_digit;
  logic [3:0]           upper_nibble;
  logic [ByteWidth-1:0] byte_index;
  logic [ByteWidth-1:0] bytes_left;
  logic [AddrWidth-1:0] rec_address;
  logic [ByteWidth-1:0] check_sum;
  logic                 parser_halted;

  hex_char_t     char_queue[$];
  parse_result_t expected_results[$];
  hex_char_t     staged;
  letter_case_t  letter_case = CaseUpper;
  bit            hold_next = 1'b0;

  int chars_total, chars_sent, results_seen, bytes_seen, records_ok;
  int mismatches, drain_pauses, stall_cycles;
  int tx_gap, tx_run, rx_gap, rx_run, hold_left;

  task automatic clear_parser();
    line_phase    = PhStart;
    second_digit  = 1'b0;
    upper_nibble  = '0;
    byte_index    = '0;
    bytes_left    = '0;
    rec_address   = '0;
    check_sum     = '0;
    parser_halted = 1'b0;
  endtask

  // Returns {valid, value} for one hex digit in either case.
  function automatic logic [4:0] nibble_of(input logic [CharWidth-1:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
    return 5'b0;
  endfunction

  function automatic parse_result_t parse_char(input logic [CharWidth-1:0] c);
    parse_result_t        r;
    logic [4:0]           nib;
    logic [ByteWidth-1:0] b;
    r = '0;
    if (!parser_halted) begin
      if (line_phase == PhSkip) begin
        if (c == ChLineFeed) line_phase = PhStart;
      end else if (line_phase < PhLen || line_phase > PhCsum) begin
        if (c == ChColon) begin
          line_phase   = PhLen;
          second_digit = 1'b0;
          byte_index   = '0;
          check_sum    = '0;
        end else begin
          r.rec_event   = 1'b1;
          r.status      = StStart;
          parser_halted = 1'b1;
        end
      end else begin
        nib = nibble_of(c);
        if (!nib[4]) begin
          r.rec_event   = 1'b1;
          r.status      = StBadHex;
          parser_halted = 1'b1;
        end else if (!second_digit) begin
          upper_nibble = nib[3:0];
          second_digit = 1'b1;
        end else begin
          b = {upper_nibble, nib[3:0]};
          second_digit = 1'b0;
          case (line_phase)
            PhLen: begin
              bytes_left = b;
              check_sum  = b;
              byte_index = '0;
              line_phase = PhAddr;
            end
            PhAddr: begin
              check_sum = check_sum + b;
              if (byte_index == 0) begin
                rec_address = {b, 8'h00};
                byte_index  = 8'd1;
              end else begin
                rec_address[7:0] = b;
                byte_index       = '0;
                line_phase       = PhType;
              end
            end
            PhType: begin
              check_sum  = check_sum + b;
              byte_index = '0;
              if (b == KindData) begin
                line_phase = (bytes_left == 0) ? PhCsum : PhData;
              end else if (b == KindEof) begin
                r.rec_event   = 1'b1;
                r.status      = StEof;
                parser_halted = 1'b1;
              end else if (b == KindExtAddr) begin
                r.rec_event   = 1'b1;
                r.status      = StExtAddr;
                parser_halted = 1'b1;
              end else begin
                line_phase = PhSkip;
              end
            end
            PhData: begin
              r.byte_valid = 1'b1;
              r.address    = 16'(rec_address + byte_index);
              r.value      = b;
              check_sum    = check_sum + b;
              byte_index   = byte_index + 8'd1;
              bytes_left   = bytes_left - 8'd1;
              if (bytes_left == 0) line_phase = PhCsum;
            end
            default: begin
              r.rec_event = 1'b1;
              if (8'(check_sum + b) == 8'h00) begin
                r.status   = StOk;
                line_phase = PhSkip;
              end else begin
                r.status      = StCsum;
                parser_halted = 1'b1;
              end
            end
          endcase
        end
      end
    end
    r.halted = parser_halted;
    return r;
  endfunction

  function automatic logic [CharWidth-1:0] digit_char(input logic [3:0] n);
    bit upper;
    upper = (letter_case == CaseUpper) ||
            (letter_case == CaseMixed && $urandom_range(0, 1) == 1);
    if (n < 10) return 8'("0" + n);
    return 8'((upper ? "A" : "a") + n - 10);
  endfunction

  task automatic add_char(input logic [CharWidth-1:0] c);
    hex_char_t h;
    h.ch          = c;
    h.drain_first = hold_next;
    hold_next     = 1'b0;
    char_queue.push_back(h);
  endtask

  task automatic add_hex_byte(input logic [ByteWidth-1:0] b);
    add_char(digit_char(b[7:4]));
    add_char(digit_char(b[3:0]));
  endtask

  // A record without its line end; sum_error skews the checksum.
  task automatic add_record(input logic [ByteWidth-1:0] len, input logic [AddrWidth-1:0] addr,
                            input logic [ByteWidth-1:0] kind, input fill_t fill,
                            input logic [ByteWidth-1:0] sum_error);
    logic [ByteWidth-1:0] sum;
    logic [ByteWidth-1:0] d;
    sum = len + addr[15:8] + addr[7:0] + kind;
    add_char(ChColon);
    add_hex_byte(len);
    add_hex_byte(addr[15:8]);
    add_hex_byte(addr[7:0]);
    add_hex_byte(kind);
    for (int i = 0; i < len; i++) begin
      case (fill)
        FillRandom: d = 8'($urandom_range(0, 255));
        FillZero:   d = 8'h00;
        FillOnes:   d = 8'hff;
        default:    d = 8'(i);
      endcase
      sum = sum + d;
      add_hex_byte(d);
    end
    add_hex_byte(8'(8'h00 - sum + sum_error));
  endtask

  // Line feed alone, carriage return first, or stray bytes first.
  task automatic add_line_end();
    int                   k;
    logic [CharWidth-1:0] g;
    k = $urandom_range(0, 3);
    if (k == 1) begin
      add_char(ChReturn);
    end else if (k >= 2) begin
      repeat ($urandom_range(1, 6)) begin
        do g = 8'($urandom_range(0, 255)); while (g == ChLineFeed);
        add_char(g);
      end
    end
    add_char(ChLineFeed);
  endtask

  function automatic logic [ByteWidth-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 8'($urandom_range(0, 8));
    if (r < 97) return 8'($urandom_range(9, 24));
    return 8'($urandom_range(25, 48));
  endfunction

  function automatic logic [AddrWidth-1:0] pick_address();
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(16'hfff0, 16'hffff));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Idle cycles before the next word, with occasional runs of back-to-back words.
  function automatic int pick_wait(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      run = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    parse_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result word %h arrived with nothing expected", $time, m_tdata);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      check_field("byte_valid", 32'(want.byte_valid), 32'(m_tdata[0]));
      check_field("byte_address", 32'(want.address), 32'(m_tdata[16:1]));
      check_field("byte_value", 32'(want.value), 32'(m_tdata[24:17]));
      check_field("record_status", 32'(want.status), 32'(m_tdata[27:25]));
      check_field("halted", 32'(want.halted), 32'(m_tdata[28]));
      check_field("record_event", 32'(want.rec_event), 32'(m_tlast));
      check_field("pad bits", 32'd0, 32'(m_tdata[31:29]));
      if (want.byte_valid) bytes_seen++;
      if (want.rec_event && want.status == StOk) records_ok++;
    end
  endtask

  // Sender: one character per word, a drawn gap after each accepted word.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
      clear_parser();
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(parse_char(s_tdata));
        chars_sent++;
        tx_gap = pick_wait(tx_run);
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (char_queue.size() > 0 &&
                     !(char_queue[0].drain_first && expected_results.size() > 0)) begin
          staged = char_queue.pop_front();
          if (staged.drain_first) drain_pauses++;
          s_tvalid <= 1'b1;
          s_tdata  <= staged.ch;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a drawn wait before taking each word, and one long hold.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap    = 0;
      hold_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result();
        results_seen++;
        rx_gap = pick_wait(rx_run);
        if (results_seen == HoldAfter) hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, StallLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    ending_t              ending;
    int                   start_idx;
    int                   pos;
    int                   pause_marks;
    logic [CharWidth-1:0] bad;
    logic [ByteWidth-1:0] len;
    logic [4:0]           nib;

    letter_case = CaseUpper;
    add_record(8'd0, 16'h0000, KindData, FillRandom, 8'd0);
    add_char(ChLineFeed);
    add_record(8'd3, 16'hffff, KindData, FillOnes, 8'd0);
    add_char(ChReturn);
    add_char(ChLineFeed);
    letter_case = CaseLower;
    add_record(8'd2, 16'habcd, KindData, FillZero, 8'd0);
    add_char(ChLineFeed);
    letter_case = CaseMixed;
    add_record(8'd1, 16'h00ef, 8'h03, FillCount, 8'd0);
    add_char(8'h00);
    add_char(8'hff);
    add_char(8'h80);
    add_char(ChColon);
    add_char(8'h7f);
    add_char(ChLineFeed);
    add_record(8'd0, 16'h8000, 8'hff, FillRandom, 8'd0);
    add_line_end();

    pause_marks = 0;
    while (char_queue.size() < ItemTarget - 20) begin
      if (pause_marks < 2 && char_queue.size() > 150 * (pause_marks + 1)) begin
        hold_next = 1'b1;
        pause_marks++;
      end
      letter_case = letter_case_t'($urandom_range(0, 2));
      if ($urandom_range(0, 99) < 80) begin
        add_record(pick_length(), pick_address(), KindData,
                   ($urandom_range(0, 7) < 5) ? FillRandom : fill_t'($urandom_range(1, 3)),
                   8'd0);
      end else begin
        add_record(pick_length(), pick_address(), 8'($urandom_range(3, 255)),
                   FillRandom, 8'd0);
      end
      add_line_end();
    end

    letter_case = CaseMixed;
    ending = ending_t'($urandom_range(0, 4));
    case (ending)
      EndChecksum: begin
        add_record(pick_length(), pick_address(), KindData, FillRandom,
                   8'($urandom_range(1, 255)));
      end
      EndBadStart: begin
        case ($urandom_range(0, 2))
          0: add_char(ChReturn);
          1: add_char(ChLineFeed);
          default: begin
            do bad = 8'($urandom_range(0, 255)); while (bad == ChColon);
            add_char(bad);
          end
        endcase
      end
      EndBadHex: begin
        len = 8'($urandom_range(1, 4));
        start_idx = char_queue.size();
        add_record(len, pick_address(), KindData, FillRandom, 8'd0);
        pos = start_idx + 1 + $urandom_range(0, 9 + 2 * len);
        do begin
          bad = 8'($urandom_range(0, 255));
          nib = nibble_of(bad);
        end while (nib[4]);
        char_queue[pos].ch = bad;
      end
      EndEof: begin
        add_record(8'd0, 16'h0000, KindEof, FillRandom, 8'd0);
      end
      default: begin
        add_record(8'd2, 16'h0000, KindExtAddr, FillRandom, 8'd0);
      end
    endcase
    add_line_end();
    add_record(8'd2, pick_address(), KindData, FillRandom, 8'd0);
    add_char(ChLineFeed);
    repeat (6) add_char(8'($urandom_range(0, 255)));
    chars_total = char_queue.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (chars_sent < chars_total || expected_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Run covered %0d characters, %0d data bytes and %0d good records, closed by %s.",
             chars_sent, bytes_seen, records_ok, ending.name());
    $display("Output held for %0d cycles once, input paused %0d times to drain; %0d mismatches.",
             LongHold, drain_pauses, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/ihex_pkg.sv
src/ihex_step.sv
src/ihex_skid.sv
src/intel_hex_record_parser.sv
src/ihex_checker.sv
tb/sv/tb_intel_hex_record_parser.sv
